>>> hw/rtl/qte_pkg.sv
// Shared package for the quaternion to Euler angle pipeline.
// Formats, payload structs, CORDIC step angles and the angle helpers.
// No dependencies.
package qte_pkg;

    localparam int COMPONENT_BITS_DEF = 16;
    localparam int ANGLE_STEPS_DEF    = 16;

    localparam int CW = 17;  // negated component
    localparam int PW = 34;  // product
    localparam int SW = 36;  // Q30 sums
    localparam int RW = 62;  // radicand
    localparam int QW = 31;  // square root
    localparam int XW = 52;  // CORDIC x/y
    localparam int ZW = 34;  // CORDIC angle, centidegrees Q16

    localparam logic [63:0]           DEG_SCALE = 64'd375493621;
    localparam logic signed [ZW-1:0]  ANGLE_45  = 34'sd294912000;
    localparam logic signed [ZW-1:0]  ANGLE_180 = 34'sd1179648000;
    localparam logic signed [SW-1:0]  ONE_Q30   = 36'sd1073741824;

    typedef struct packed {
        logic signed [31:0]   s;
        logic signed [SW-1:0] rn;
        logic signed [SW-1:0] rd;
        logic signed [SW-1:0] yn;
        logic signed [SW-1:0] yd;
        logic                 clamped;
    } t_side;

    typedef struct packed {
        logic                 zero;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_vec;

    function automatic logic signed [ZW-1:0] step_angle(input int i);
        logic [63:0]        big;
        logic [63:0]        term;
        logic signed [63:0] sum;
        int                 e;
        big = DEG_SCALE << 32;
        sum = '0;
        if (i == 0) begin
            return ANGLE_45;
        end
        for (int k = 0; k < 32; k++) begin
            e = i * (2 * k + 1);
            if (e < 63) begin
                term = (big >> e) / 64'(2 * k + 1);
                if (k % 2 == 1) sum = sum - $signed(term);
                else            sum = sum + $signed(term);
            end
        end
        sum = (sum + 64'sd2147483648) >>> 32;
        return sum[ZW-1:0];
    endfunction

    function automatic t_vec vec_prep(input logic signed [SW-1:0] y,
                                      input logic signed [SW-1:0] x);
        t_vec                 v;
        logic signed [SW-1:0] xa;
        logic signed [SW-1:0] ya;
        v.zero = (x == '0) && (y == '0);
        v.z    = '0;
        xa     = x;
        ya     = y;
        if (x < 0) begin
            v.z = (y >= 0) ? ANGLE_180 : -ANGLE_180;
            xa  = -x;
            ya  = -y;
        end
        v.x = XW'(xa) <<< 16;
        v.y = XW'(ya) <<< 16;
        return v;
    endfunction

    function automatic logic [15:0] round_angle(input logic signed [ZW-1:0] z,
                                                input logic neg,
                                                input logic signed [ZW-1:0] lim);
        logic signed [ZW-1:0] a;
        logic signed [ZW-1:0] r;
        a = neg ? -z : z;
        r = (a + 34'sd32768) >>> 16;
        if (r > lim)       r = lim;
        else if (r < -lim) r = -lim;
        return r[15:0];
    endfunction

endpackage

>>> hw/rtl/qte_front.sv
// Front stages: component products, Q30 sums, saturation and the radicand
// 2^60 - s^2 built from two registered partial products. Uses qte_pkg.
module qte_front import qte_pkg::*; #(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [COMPONENT_BITS-1:0] i_quat_x,
    input  logic [COMPONENT_BITS-1:0] i_quat_y,
    input  logic [COMPONENT_BITS-1:0] i_quat_z,
    input  logic [COMPONENT_BITS-1:0] i_quat_w,
    output logic                      o_valid,
    output t_side                     o_side,
    output logic [RW-1:0]             o_rad
);

    localparam int DROP   = (COMPONENT_BITS > 16) ? COMPONENT_BITS - 16 : 0;
    localparam int KEEP   = COMPONENT_BITS - DROP;
    localparam int UP_SH  = 30 - 2 * (KEEP - 1);

    logic signed [COMPONENT_BITS-1:0] sh_x, sh_y, sh_z, sh_w;
    logic signed [KEEP-1:0]           k_x, k_y, k_z, k_w;
    logic signed [CW-1:0]             c_x, c_y, c_z, c_w;

    assign sh_x = $signed(i_quat_x) >>> DROP;
    assign sh_y = $signed(i_quat_y) >>> DROP;
    assign sh_z = $signed(i_quat_z) >>> DROP;
    assign sh_w = $signed(i_quat_w) >>> DROP;
    assign k_x  = sh_x[KEEP-1:0];
    assign k_y  = sh_y[KEEP-1:0];
    assign k_z  = sh_z[KEEP-1:0];
    assign k_w  = sh_w[KEEP-1:0];
    assign c_x  = -CW'(k_x);
    assign c_y  = CW'(k_y);
    assign c_z  = -CW'(k_z);
    assign c_w  = CW'(k_w);

    // stage 1: products
    logic signed [PW-1:0] r1_xx, r1_yy, r1_zz, r1_ww, r1_xz, r1_wy;
    logic signed [PW-1:0] r1_wx, r1_yz, r1_wz, r1_xy;
    logic                 r1_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_xx <= c_x * c_x;
            r1_yy <= c_y * c_y;
            r1_zz <= c_z * c_z;
            r1_ww <= c_w * c_w;
            r1_xz <= c_x * c_z;
            r1_wy <= c_w * c_y;
            r1_wx <= c_w * c_x;
            r1_yz <= c_y * c_z;
            r1_wz <= c_w * c_z;
            r1_xy <= c_x * c_y;
        end
    end

    // stage 2: Q30 sums and saturation
    logic signed [SW-1:0] s_full;
    t_side                n_side2;
    t_side                r2_side;
    logic                 r2_v;

    always_comb begin
        s_full          = (SW'(r1_xz) - SW'(r1_wy)) <<< (UP_SH + 1);
        n_side2.rn      = (SW'(r1_wx) + SW'(r1_yz)) <<< (UP_SH + 1);
        n_side2.yn      = (SW'(r1_wz) + SW'(r1_xy)) <<< (UP_SH + 1);
        n_side2.rd      = (SW'(r1_ww) - SW'(r1_xx) - SW'(r1_yy) + SW'(r1_zz)) <<< UP_SH;
        n_side2.yd      = (SW'(r1_ww) + SW'(r1_xx) - SW'(r1_yy) - SW'(r1_zz)) <<< UP_SH;
        n_side2.clamped = (s_full > ONE_Q30) || (s_full < -ONE_Q30);
        if (s_full > ONE_Q30)       n_side2.s = ONE_Q30[31:0];
        else if (s_full < -ONE_Q30) n_side2.s = -ONE_Q30[31:0];
        else                        n_side2.s = s_full[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_side <= n_side2;
        end
    end

    // stage 3: (1 - |s|)(1 + |s|) as two partial products
    logic [31:0]   mag;
    logic [30:0]   fa;
    logic [31:0]   fb;
    logic [46:0]   r3_plo, r3_phi;
    t_side         r3_side;
    logic          r3_v;

    assign mag = r2_side.s[31] ? 32'(-r2_side.s) : 32'(r2_side.s);
    assign fa  = 31'h4000_0000 - mag[30:0];
    assign fb  = 32'h4000_0000 + mag;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_plo  <= 47'(fa) * 47'(fb[15:0]);
            r3_phi  <= 47'(fa) * 47'(fb[31:16]);
            r3_side <= r2_side;
        end
    end

    // stage 4: radicand
    logic [RW-1:0] r4_rad;
    t_side         r4_side;
    logic          r4_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_rad  <= RW'(r3_plo) + (RW'(r3_phi) << 16);
            r4_side <= r3_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    assign o_valid = r4_v;
    assign o_side  = r4_side;
    assign o_rad   = r4_rad;

endmodule

>>> hw/rtl/qte_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per cycle while i_en is high.
// Uses qte_pkg.
module qte_sqrt_cell import qte_pkg::*; #(
    parameter int BIT = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [RW-1:0] i_rem,
    input  logic [QW-1:0] i_root,
    output logic [RW-1:0] o_rem,
    output logic [QW-1:0] o_root
);

    localparam logic [RW-1:0] ONE_BIT = RW'(1) << (2 * BIT);

    logic [RW-1:0] trial;
    logic [RW-1:0] r_rem;
    logic [QW-1:0] r_root;

    assign trial = (RW'(i_root) << (BIT + 1)) | ONE_BIT;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_rem >= trial) begin
                r_rem  <= i_rem - trial;
                r_root <= i_root | (QW'(1) << BIT);
            end else begin
                r_rem  <= i_rem;
                r_root <= i_root;
            end
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

>>> hw/rtl/qte_cordic_cell.sv
// One CORDIC vectoring cell: one rotation step per cycle while i_en is high.
// Uses qte_pkg (step_angle, t_vec).
module qte_cordic_cell import qte_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_vec i_vec,
    output t_vec o_vec
);

    localparam logic signed [ZW-1:0] ANGLE = step_angle(STEP);

    logic signed [XW-1:0] dx, dy;
    t_vec                 n_vec;
    t_vec                 r_vec;

    assign dx = i_vec.y >>> STEP;
    assign dy = i_vec.x >>> STEP;

    always_comb begin
        n_vec = i_vec;
        if (!i_vec.zero) begin
            if (i_vec.y < 0) begin
                n_vec.x = i_vec.x - dx;
                n_vec.y = i_vec.y + dy;
                n_vec.z = i_vec.z - ANGLE;
            end else begin
                n_vec.x = i_vec.x + dx;
                n_vec.y = i_vec.y - dy;
                n_vec.z = i_vec.z + ANGLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;

endmodule

>>> hw/rtl/quaternion_to_euler_degrees.sv
// Quaternion to pitch/roll/yaw in centidegrees, fully pipelined.
// Uses qte_pkg, qte_front, qte_sqrt_cell and qte_cordic_cell.
//
// Input channel: i_valid / o_stall with the four quaternion components.
// Output channel: o_valid / i_stall with pitch, roll, yaw and sine_clamped.
// An item moves on a rising edge with valid high and stall low.
// Throughput: one item per cycle while o_stall is low. Pipeline: 4 front
// stages, 31 square-root cells, 1 quadrant stage, ANGLE_STEPS CORDIC
// cells and 1 rounding stage.
// Every stage is one register; the square root and the three CORDIC
// lanes are rows of cells that advance together.
// A stalled result is parked in a one-item skid register; while it is
// full the whole pipeline holds and o_stall is high, so o_stall is a
// register and never follows i_stall in the same cycle.
// Reset (synchronous, active low) clears all valid bits; the block
// accepts items in the first cycle after reset.
module quaternion_to_euler_degrees import qte_pkg::*; #(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
    parameter int ANGLE_STEPS    = ANGLE_STEPS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [COMPONENT_BITS-1:0] i_quat_x,
    input  logic [COMPONENT_BITS-1:0] i_quat_y,
    input  logic [COMPONENT_BITS-1:0] i_quat_z,
    input  logic [COMPONENT_BITS-1:0] i_quat_w,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [14:0]               o_pitch_centideg,
    output logic [15:0]               o_roll_centideg,
    output logic [15:0]               o_yaw_centideg,
    output logic                      o_sine_clamped
);

    logic en;
    logic r_skid_valid;

    assign en      = !r_skid_valid;
    assign o_stall = r_skid_valid;

    // front
    logic          f_valid;
    t_side         f_side;
    logic [RW-1:0] f_rad;

    qte_front #(.COMPONENT_BITS(COMPONENT_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_quat_x (i_quat_x),
        .i_quat_y (i_quat_y),
        .i_quat_z (i_quat_z),
        .i_quat_w (i_quat_w),
        .o_valid  (f_valid),
        .o_side   (f_side),
        .o_rad    (f_rad)
    );

    // square root row
    logic [RW-1:0] w_rem  [0:QW];
    logic [QW-1:0] w_root [0:QW];
    t_side         r_side [0:QW-1];
    logic          r_sv   [0:QW-1];

    assign w_rem[0]  = f_rad;
    assign w_root[0] = '0;

    for (genvar j = 0; j < QW; j++) begin : g_sqrt
        qte_sqrt_cell #(.BIT(QW - 1 - j)) u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_rem  (w_rem[j]),
            .i_root (w_root[j]),
            .o_rem  (w_rem[j+1]),
            .o_root (w_root[j+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= f_side;
            for (int j = 1; j < QW; j++) r_side[j] <= r_side[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < QW; j++) r_sv[j] <= 1'b0;
        end else if (en) begin
            r_sv[0] <= f_valid;
            for (int j = 1; j < QW; j++) r_sv[j] <= r_sv[j-1];
        end
    end

    // quadrant stage and CORDIC rows: lane 0 pitch, 1 roll, 2 yaw
    t_side q_side;
    t_vec  r_prep [0:2];
    t_vec  w_vec  [0:2][0:ANGLE_STEPS];
    logic  r_cv   [0:ANGLE_STEPS];
    logic  r_cf   [0:ANGLE_STEPS];

    assign q_side = r_side[QW-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prep[0] <= vec_prep(SW'(q_side.s), SW'({1'b0, w_root[QW]}));
            r_prep[1] <= vec_prep(q_side.rn, q_side.rd);
            r_prep[2] <= vec_prep(q_side.yn, q_side.yd);
            r_cf[0]   <= q_side.clamped;
            for (int k = 1; k <= ANGLE_STEPS; k++) r_cf[k] <= r_cf[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= ANGLE_STEPS; k++) r_cv[k] <= 1'b0;
        end else if (en) begin
            r_cv[0] <= r_sv[QW-1];
            for (int k = 1; k <= ANGLE_STEPS; k++) r_cv[k] <= r_cv[k-1];
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign w_vec[l][0] = r_prep[l];
        for (genvar k = 0; k < ANGLE_STEPS; k++) begin : g_step
            qte_cordic_cell #(.STEP(k)) u_cell (
                .i_clk (i_clk),
                .i_en  (en),
                .i_vec (w_vec[l][k]),
                .o_vec (w_vec[l][k+1])
            );
        end
    end

    // rounding stage
    logic [15:0] n_pitch;
    logic [14:0] r_p_pitch;
    logic [15:0] r_p_roll, r_p_yaw;
    logic        r_p_flag;
    logic        r_pv;

    assign n_pitch = round_angle(w_vec[0][ANGLE_STEPS].z, 1'b1, 34'sd9000);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_pitch <= n_pitch[14:0];
            r_p_roll  <= round_angle(w_vec[1][ANGLE_STEPS].z, 1'b0, 34'sd18000);
            r_p_yaw   <= round_angle(w_vec[2][ANGLE_STEPS].z, 1'b0, 34'sd18000);
            r_p_flag  <= r_cf[ANGLE_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (en) begin
            r_pv <= r_cv[ANGLE_STEPS];
        end
    end

    // skid register
    logic [14:0] r_s_pitch;
    logic [15:0] r_s_roll, r_s_yaw;
    logic        r_s_flag;
    logic        n_skid_valid;

    always_comb begin
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (!i_stall) n_skid_valid = 1'b0;
        end else if (r_pv && i_stall) begin
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else begin
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid && r_pv && i_stall) begin
            r_s_pitch <= r_p_pitch;
            r_s_roll  <= r_p_roll;
            r_s_yaw   <= r_p_yaw;
            r_s_flag  <= r_p_flag;
        end
    end

    assign o_valid          = r_skid_valid || r_pv;
    assign o_pitch_centideg = r_skid_valid ? r_s_pitch : r_p_pitch;
    assign o_roll_centideg  = r_skid_valid ? r_s_roll  : r_p_roll;
    assign o_yaw_centideg   = r_skid_valid ? r_s_yaw   : r_p_yaw;
    assign o_sine_clamped   = r_skid_valid ? r_s_flag  : r_p_flag;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("valid or stall set after reset");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_pv && i_stall))
        else $error("skid filled without a stalled result");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $signed(o_roll_centideg) <= 16'sd18000
                 && $signed(o_roll_centideg) >= -16'sd18000
                 && $signed(o_yaw_centideg) <= 16'sd18000
                 && $signed(o_yaw_centideg) >= -16'sd18000
                 && $signed(o_pitch_centideg) <= 15'sd9000
                 && $signed(o_pitch_centideg) >= -15'sd9000)
        else $error("angle out of range");

endmodule
